@@ design/emld_pkg.sv @@
// ---------------------------------------------------------------------------
// emld_pkg: shared types and constants
// Menu codes, pattern constants, register map and the segment code table.
// ---------------------------------------------------------------------------
package emld_pkg;

	localparam int DISPLAY_DIGITS_DEF = 4;

	// register map (word index taken from paddr[2])
	localparam logic REG_PATTERN_PERIOD = 1'b0;
	localparam logic [7:0] PERIOD_RESET = 8'd100;

	// menu entries
	localparam logic [2:0] MENU_BLINK  = 3'd1;
	localparam logic [2:0] MENU_COUNT  = 3'd2;
	localparam logic [2:0] MENU_RING   = 3'd3;
	localparam logic [2:0] MENU_TOGGLE = 3'd4;
	localparam logic [2:0] MENU_MIN    = MENU_BLINK;
	localparam logic [2:0] MENU_MAX    = MENU_TOGGLE;

	// ring of eight LEDs
	localparam logic [7:0] RING_LEN = 8'd8;
	localparam int RING_W = 3;

	localparam int EN_W = 4;

	typedef struct packed {
		logic button_level;
		logic encoder_b;
		logic encoder_a;
	} in_item_t;

	typedef struct packed {
		logic       running;
		logic [2:0] menu_number;
		logic [7:0] segment_bits;
		logic [3:0] digit_enable;
		logic [7:0] led_pattern;
	} result_t;

	// common-anode, active-low codes for decimal digits
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0: c = 8'hC0;
			4'd1: c = 8'hF9;
			4'd2: c = 8'hA4;
			4'd3: c = 8'hB0;
			4'd4: c = 8'h99;
			4'd5: c = 8'h92;
			4'd6: c = 8'h82;
			4'd7: c = 8'hF8;
			4'd8: c = 8'h80;
			4'd9: c = 8'h90;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

endpackage

@@ design/emld_cfg.sv @@
// ---------------------------------------------------------------------------
// emld_cfg: configuration register file
// APB-style port holding the pattern period register.
// ---------------------------------------------------------------------------
module emld_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  pattern_period
);

	logic [7:0] period_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready
		&& (paddr[2] == emld_pkg::REG_PATTERN_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= emld_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			period_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == emld_pkg::REG_PATTERN_PERIOD) begin
			prdata = {24'd0, period_q};
		end
	end

	assign pattern_period = period_q;

endmodule

@@ design/emld_ctrl.sv @@
// ---------------------------------------------------------------------------
// emld_ctrl: menu, run control and pattern generator
// Encoder and button handling plus LED pattern state, one tick per fire.
// ---------------------------------------------------------------------------
module emld_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  emld_pkg::in_item_t  item,
	input  logic [7:0]          pattern_period,
	output logic [7:0]          led_nxt,
	output logic [2:0]          menu_nxt,
	output logic                run_nxt
);

	logic       last_a_q, armed_q, run_q;
	logic [2:0] menu_q;
	logic [7:0] tick_q, step_q, led_q;

	logic       last_a_d, armed_d, run_d;
	logic [2:0] menu_d;
	logic [7:0] tick_d, step_d, led_d;
	logic [7:0] step_inc, ring_next, ring_mask;

	always_comb begin
		last_a_d = last_a_q;
		armed_d  = armed_q;
		run_d    = run_q;
		menu_d   = menu_q;
		tick_d   = tick_q;
		step_d   = step_q;
		led_d    = led_q;

		// encoder: menu only moves while stopped
		if (item.encoder_a != last_a_q) begin
			last_a_d = item.encoder_a;
			if (!run_q) begin
				if (item.encoder_b == item.encoder_a) begin
					if (menu_q > emld_pkg::MENU_MIN) menu_d = menu_q - 3'd1;
				end else begin
					if (menu_q < emld_pkg::MENU_MAX) menu_d = menu_q + 3'd1;
				end
			end
		end

		// button: falling edge toggles running
		if (item.button_level) armed_d = 1'b1;
		if (armed_d && !item.button_level) begin
			armed_d = 1'b0;
			run_d   = !run_q;
			if (!run_d) begin
				led_d  = 8'd0;
				step_d = 8'd0;
				tick_d = 8'd0;
			end
		end

		step_inc  = step_d + 8'd1;
		ring_next = (step_inc >= emld_pkg::RING_LEN) ? 8'd0 : step_inc;
		ring_mask = (step_d < emld_pkg::RING_LEN) ?
			(8'd1 << step_d[emld_pkg::RING_W-1:0]) : 8'd0;

		if (run_d && (tick_d == pattern_period)) begin
			tick_d = 8'd0;
			case (menu_d)
				emld_pkg::MENU_BLINK: begin
					led_d = ~led_d;
				end
				emld_pkg::MENU_COUNT: begin
					step_d = step_inc;
					led_d  = step_inc;
				end
				emld_pkg::MENU_RING: begin
					led_d  = ring_mask;
					step_d = ring_next;
				end
				emld_pkg::MENU_TOGGLE: begin
					led_d  = led_d ^ ring_mask;
					step_d = ring_next;
				end
				default: begin
				end
			endcase
		end

		tick_d = tick_d + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b1;
			armed_q  <= 1'b1;
			menu_q   <= emld_pkg::MENU_MIN;
			run_q    <= 1'b0;
			tick_q   <= 8'd0;
			step_q   <= 8'd0;
			led_q    <= 8'd0;
		end else if (fire) begin
			last_a_q <= last_a_d;
			armed_q  <= armed_d;
			menu_q   <= menu_d;
			run_q    <= run_d;
			tick_q   <= tick_d;
			step_q   <= step_d;
			led_q    <= led_d;
		end
	end

	assign led_nxt  = led_d;
	assign menu_nxt = menu_d;
	assign run_nxt  = run_d;

endmodule

@@ design/emld_disp.sv @@
// ---------------------------------------------------------------------------
// emld_disp: display scan
// Digit scan counter and seven-segment decode of the menu number.
// ---------------------------------------------------------------------------
module emld_disp #(
	parameter int DISPLAY_DIGITS = emld_pkg::DISPLAY_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [2:0] menu_nxt,
	output logic [3:0] digit_enable,
	output logic [7:0] segment_bits
);

	localparam int SCAN_W = (DISPLAY_DIGITS > 1) ? $clog2(DISPLAY_DIGITS) : 1;
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DISPLAY_DIGITS - 1);

	logic [SCAN_W-1:0] scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (fire) begin
			scan_q <= (scan_q == SCAN_LAST) ? '0 : scan_q + SCAN_W'(1);
		end
	end

	// menu is a single decimal digit: higher places show zero
	always_comb begin
		digit_enable = '0;
		if (32'(scan_q) < emld_pkg::EN_W) begin
			digit_enable = 4'(8'd1 << scan_q);
		end
		segment_bits = (scan_q == '0) ? emld_pkg::seg_code({1'b0, menu_nxt})
			: emld_pkg::seg_code(4'd0);
	end

endmodule

@@ design/encoder_menu_led_pattern_display_top.sv @@
// ---------------------------------------------------------------------------
// encoder_menu_led_pattern_display_top: encoder menu and LED pattern display
// Scan-tick driven menu, run control, LED pattern and display scan.
// ---------------------------------------------------------------------------
// Each slave-side transaction is one scan tick carrying the sampled encoder
// pins and the push button; each tick yields exactly one master-side
// transaction with the LED bits, the scanned digit enable and segment code,
// the menu entry and the run flag. Rotating the encoder while stopped picks
// menu 1 to 4 (blink, binary count, ring, toggling ring); a button press
// starts or stops the pattern, and stopping clears the LEDs. The pattern
// advances each time the free-running 8-bit tick count reaches
// pattern_period (register at byte address 0). Throughput is one tick per
// clock while m_tready is high. The input register captures a tick on
// acceptance, and the result register takes the processed tick once it is
// free or being emptied, then offers it on m_tvalid. The result register
// lets a new tick be taken while an earlier result waits for m_tready.
// ---------------------------------------------------------------------------
module encoder_menu_led_pattern_display_top #(
	parameter int DISPLAY_DIGITS = emld_pkg::DISPLAY_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [0] encoder_a, [1] encoder_b, [2] button_level
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] led_pattern, [11:8] digit_enable,
	                              // [19:12] segment_bits, [22:20] menu_number,
	                              // [23] running
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                valid_s1;
	emld_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	emld_pkg::result_t   result_q;
	emld_pkg::result_t   result_d;
	logic                fire;
	logic [7:0]          pattern_period;

	// a tick is processed when the result register is free or being emptied
	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= emld_pkg::in_item_t'(s_tdata[2:0]);
		end
	end

	emld_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.pattern_period (pattern_period)
	);

	emld_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.pattern_period (pattern_period),
		.led_nxt        (result_d.led_pattern),
		.menu_nxt       (result_d.menu_number),
		.run_nxt        (result_d.running)
	);

	emld_disp #(
		.DISPLAY_DIGITS (DISPLAY_DIGITS)
	) u_disp (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.menu_nxt     (result_d.menu_number),
		.digit_enable (result_d.digit_enable),
		.segment_bits (result_d.segment_bits)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

endmodule

@@ tb/sv/encoder_menu_led_pattern_display_top_tb.sv @@
// ---------------------------------------------------------------------------
// encoder_menu_led_pattern_display_top_tb: self-checking bench for the menu
// Scan ticks go in on the slave stream. Each result on the master stream is
// compared field by field against a cycle-free model of menu, run control,
// LED patterns and display scan. Covers menu limits, every pattern, period
// extremes, output back-pressure and random encoder/button sessions.
// ---------------------------------------------------------------------------
module encoder_menu_led_pattern_display_top_tb;

	localparam int DISPLAY_DIGITS = emld_pkg::DISPLAY_DIGITS_DEF;
	// word 0 holds pattern_period
	localparam logic [2:0] PERIOD_ADDR = {emld_pkg::REG_PATTERN_PERIOD, 2'b00};
	// receiver hold-off for the back-pressure test, in clock cycles
	localparam int HOLD_CYCLES = 60;
	// mismatch lines printed before going quiet (counting carries on)
	localparam int REPORT_CAP = 40;

	// DUT signals; the inputs are known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// model state, starting at the reset values
	logic       enc_a_prev = 1'b1;
	logic       btn_armed = 1'b1;
	logic [2:0] menu_sel = emld_pkg::MENU_MIN;
	logic       is_running = 1'b0;
	logic [7:0] tick_cnt = 8'd0;
	logic [7:0] step_cnt = 8'd0;
	logic [7:0] led_bits = 8'd0;
	int         scan_pos = 0;
	logic [7:0] period_reg = emld_pkg::PERIOD_RESET;

	// results predicted but not yet seen on the master side
	emld_pkg::result_t frames_due[$];

	// stimulus and checking statistics
	int n_ticks = 0;
	int n_checked = 0;
	int n_settings = 0;
	int err_cnt = 0;

	// idling controls; the hold-off request is a toggle seen by the receiver
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit rx_hold_trig = 1'b0;

	encoder_menu_led_pattern_display_top #(
		.DISPLAY_DIGITS(DISPLAY_DIGITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [0] encoder_a, [1] encoder_b, [2] button_level
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] led, [11:8] digit_enable, [19:12] segments,
		                       // [22:20] menu_number, [23] running
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// common-anode, active-low glyphs for 0..9
	function automatic logic [7:0] glyph_for(input int d);
		case (d)
			0: return 8'hC0;
			1: return 8'hF9;
			2: return 8'hA4;
			3: return 8'hB0;
			4: return 8'h99;
			5: return 8'h92;
			6: return 8'h82;
			7: return 8'hF8;
			8: return 8'h80;
			default: return 8'h90;
		endcase
	endfunction

	// single LED of the ring; empty once the step runs off the end
	function automatic logic [7:0] ring_mask(input logic [7:0] s);
		return (s < emld_pkg::RING_LEN) ? (8'd1 << s) : 8'd0;
	endfunction

	function automatic logic [7:0] ring_next(input logic [7:0] s);
		logic [7:0] n;
		n = s + 8'd1;
		return (n >= emld_pkg::RING_LEN) ? 8'd0 : n;
	endfunction

	// Advance the model by one scan tick and return the frame it produces.
	function automatic emld_pkg::result_t next_display_frame(
			input emld_pkg::in_item_t item);
		emld_pkg::result_t r;
		int v;
		int k;
		// encoder: any change of A moves the menu, but only while stopped
		if (item.encoder_a != enc_a_prev) begin
			enc_a_prev = item.encoder_a;
			if (!is_running) begin
				if (item.encoder_b == item.encoder_a) begin
					if (menu_sel > emld_pkg::MENU_MIN)
						menu_sel = menu_sel - 3'd1;
				end else if (menu_sel < emld_pkg::MENU_MAX) begin
					menu_sel = menu_sel + 3'd1;
				end
			end
		end
		// button: falling edge toggles running; stopping clears the pattern
		if (item.button_level)
			btn_armed = 1'b1;
		if (btn_armed && !item.button_level) begin
			btn_armed = 1'b0;
			is_running = ~is_running;
			if (!is_running) begin
				led_bits = 8'd0;
				step_cnt = 8'd0;
				tick_cnt = 8'd0;
			end
		end
		// pattern step when the free-running count hits the period
		if (is_running && tick_cnt == period_reg) begin
			tick_cnt = 8'd0;
			case (menu_sel)
				emld_pkg::MENU_BLINK: led_bits = ~led_bits;
				emld_pkg::MENU_COUNT: begin
					step_cnt = step_cnt + 8'd1;
					led_bits = step_cnt;
				end
				emld_pkg::MENU_RING: begin
					led_bits = ring_mask(step_cnt);
					step_cnt = ring_next(step_cnt);
				end
				emld_pkg::MENU_TOGGLE: begin
					led_bits = led_bits ^ ring_mask(step_cnt);
					step_cnt = ring_next(step_cnt);
				end
				default: ;
			endcase
		end
		// display: decimal digit of the menu at the scanned position
		v = menu_sel;
		for (k = 0; k < scan_pos; k++)
			v = v / 10;
		r.led_pattern  = led_bits;
		r.digit_enable = (scan_pos < emld_pkg::EN_W) ? 4'(1 << scan_pos) : 4'd0;
		r.segment_bits = glyph_for(v % 10);
		r.menu_number  = menu_sel;
		r.running      = is_running;
		scan_pos = (scan_pos + 1 >= DISPLAY_DIGITS) ? 0 : scan_pos + 1;
		tick_cnt = tick_cnt + 8'd1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (err_cnt < REPORT_CAP)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
				what, got, want, n_checked);
		err_cnt++;
	endtask

	// Receiver: random stalls, plus a long hold-off counted here on request.
	initial begin : receiver
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_trig != hold_seen) begin
				hold_seen = rx_hold_trig;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (rx_idle_on && $urandom_range(99) < 25) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker: every master-side transaction against the oldest frame.
	always @(posedge clk) begin
		emld_pkg::result_t got;
		emld_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = emld_pkg::result_t'(m_tdata);
			if (frames_due.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = frames_due.pop_front();
				if (got.led_pattern !== want.led_pattern)
					report_mismatch("led_pattern", got.led_pattern, want.led_pattern);
				if (got.digit_enable !== want.digit_enable)
					report_mismatch("digit_enable", got.digit_enable, want.digit_enable);
				if (got.segment_bits !== want.segment_bits)
					report_mismatch("segment_bits", got.segment_bits, want.segment_bits);
				if (got.menu_number !== want.menu_number)
					report_mismatch("menu_number", got.menu_number, want.menu_number);
				if (got.running !== want.running)
					report_mismatch("running", got.running, want.running);
			end
			n_checked++;
		end
	end

	// One scan tick on the slave side; the frame is predicted on acceptance.
	// tvalid stays high on return so back-to-back ticks need no re-raise.
	task automatic send_tick(input logic a, input logic b, input logic btn);
		emld_pkg::in_item_t item;
		item.encoder_a    = a;
		item.encoder_b    = b;
		item.button_level = btn;
		if (tx_idle_on && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, item};
		do @(posedge clk); while (!s_tready);
		frames_due.push_back(next_display_frame(item));
		n_ticks++;
	endtask

	// Press and release: low for a few ticks, then high again.
	task automatic press_button();
		repeat ($urandom_range(1, 3))
			send_tick(enc_a_prev, 1'($urandom_range(1)), 1'b0);
		send_tick(enc_a_prev, 1'($urandom_range(1)), 1'b1);
	endtask

	// Sender stops and waits for every outstanding frame, plus the pipe depth.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup and access phase, then an idle phase with psel low before the next access.
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PERIOD_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_period();
		logic [31:0] rd;
		apb_access(1'b0, 32'd0, rd);
		if (rd[7:0] !== period_reg)
			report_mismatch("pattern_period readback", rd[7:0], period_reg);
	endtask

	// Reprogram the period only with the block idle.
	task automatic set_period(input logic [7:0] val);
		logic [31:0] rd;
		drain();
		apb_access(1'b1, {24'd0, val}, rd);
		period_reg = val;
		check_period();
		n_settings++;
	endtask

	task automatic test_reset_value();
		check_period();
	endtask

	// Walk the menu into both ends and past them.
	task automatic test_menu_limits();
		send_tick(1'b0, 1'b0, 1'b1);   // down at 1: stays
		send_tick(1'b1, 1'b1, 1'b1);   // down again: stays
		send_tick(1'b0, 1'b1, 1'b1);   // up to 2
		send_tick(1'b1, 1'b0, 1'b1);   // 3
		send_tick(1'b0, 1'b1, 1'b1);   // 4
		send_tick(1'b1, 1'b0, 1'b1);   // up at 4: stays
		send_tick(1'b0, 1'b0, 1'b1);   // back down to 3
		send_tick(1'b1, 1'b1, 1'b1);   // 2
		send_tick(1'b0, 1'b0, 1'b1);   // 1
	endtask

	// Run each pattern briefly at period 1, turning the encoder meanwhile
	// (must be ignored), then step the menu up; the last step saturates.
	task automatic test_each_pattern();
		int m;
		set_period(8'd1);
		for (m = 0; m < 4; m++) begin
			press_button();
			send_tick(~enc_a_prev, 1'b0, 1'b1);
			send_tick(~enc_a_prev, 1'b1, 1'b1);
			send_tick(enc_a_prev, 1'b0, 1'b1);
			press_button();
			send_tick(~enc_a_prev, enc_a_prev, 1'b1);
		end
	endtask

	// Receiver holds off while the sender keeps offering: input must stall.
	task automatic test_output_stall();
		int k;
		drain();
		tx_idle_on = 1'b0;
		rx_hold_trig = ~rx_hold_trig;
		press_button();
		for (k = 0; k < 36; k++)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
		press_button();
		tx_idle_on = 1'b1;
	endtask

	// Sender pauses until the result stream is empty, then resumes.
	task automatic test_sender_pause();
		int k;
		for (k = 0; k < 10; k++)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		drain();
		for (k = 0; k < 10; k++)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Random sessions: mostly turn-press-run-press, some raw noise.
	task automatic run_sessions(input int n_items, input int run_max);
		int start;
		int len;
		int k;
		int left;
		start = n_ticks;
		while (n_ticks - start < n_items) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 5))
					send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(0, 5))
					send_tick(~enc_a_prev, 1'($urandom_range(1)), 1'b1);
				press_button();
				// keep the run inside what is left of this phase
				left = n_items - (n_ticks - start);
				len = $urandom_range(4, run_max);
				if (len > left)
					len = left;
				for (k = 0; k < len; k++) begin
					if ($urandom_range(4) == 0)
						send_tick(~enc_a_prev, 1'($urandom_range(1)), 1'b1);
					else
						send_tick(enc_a_prev, 1'($urandom_range(1)), 1'b1);
				end
				press_button();
			end
		end
	endtask

	// Several period settings, extremes included (zero advances on wrap).
	task automatic test_random_phases();
		set_period(8'd1);
		run_sessions(250, 40);
		set_period(8'd2);
		run_sessions(200, 40);
		// stretch with no idling on either side
		set_period(8'($urandom_range(3, 8)));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_sessions(200, 40);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_period(8'd0);
		run_sessions(250, 600);
		set_period(8'd255);
		run_sessions(250, 600);
		set_period(8'($urandom_range(1, 255)));
		run_sessions(150, 300);
		set_period(emld_pkg::PERIOD_RESET);
		run_sessions(150, 300);
	endtask

	initial begin : main
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_menu_limits();
		test_each_pattern();
		test_output_stall();
		test_sender_pause();
		test_random_phases();

		// let the pipe empty, bounded, then settle
		s_tvalid <= 1'b0;
		waited = 0;
		while (frames_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (frames_due.size() != 0)
			report_mismatch("results never delivered", 0, frames_due.size());

		$display("Covered %0d ticks over %0d period settings: menu limits, all four",
			n_ticks, n_settings);
		$display("patterns, period 0/1/255, back-pressure; %0d results compared, %0d errors",
			n_checked, err_cnt);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ encoder_menu_led_pattern_display_top.f @@
design/emld_pkg.sv
design/emld_cfg.sv
design/emld_ctrl.sv
design/emld_disp.sv
design/encoder_menu_led_pattern_display_top.sv
tb/sv/encoder_menu_led_pattern_display_top_tb.sv
